// ===== design/lcab_pkg.sv =====
// lcab_pkg: shared constants, step codes and control structs of the lca engine
// no dependencies; used by every other file of the block but lcab_ram
package lcab_pkg;

	// field widths
	localparam int NODE_W = 11;
	localparam int FUNC_W = 2;
	localparam int LEN_W  = 11;
	localparam int CFG_W  = 11;

	// default sizing
	localparam int DEF_MAX_NODES  = 1024;
	localparam int DEF_LOG_LEVELS = 11;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1;

	// function codes of an input word
	localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_BUILD = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

	// special nodes
	localparam logic [NODE_W-1:0] NULL_NODE = 11'd0;
	localparam logic [NODE_W-1:0] ROOT_NODE = 11'd1;

	// controller steps, also the datapath opcode
	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_CLR   = 5'd0;
	localparam logic [ST_W-1:0] ST_IDLE  = 5'd1;
	localparam logic [ST_W-1:0] ST_LOAD  = 5'd2;
	localparam logic [ST_W-1:0] ST_B0R   = 5'd3;
	localparam logic [ST_W-1:0] ST_B0W   = 5'd4;
	localparam logic [ST_W-1:0] ST_LVR   = 5'd5;
	localparam logic [ST_W-1:0] ST_LVM   = 5'd6;
	localparam logic [ST_W-1:0] ST_LVW   = 5'd7;
	localparam logic [ST_W-1:0] ST_DPR   = 5'd8;
	localparam logic [ST_W-1:0] ST_DPS   = 5'd9;
	localparam logic [ST_W-1:0] ST_QMAP  = 5'd10;
	localparam logic [ST_W-1:0] ST_QRD   = 5'd11;
	localparam logic [ST_W-1:0] ST_QPICK = 5'd12;
	localparam logic [ST_W-1:0] ST_UPR   = 5'd13;
	localparam logic [ST_W-1:0] ST_UPD   = 5'd14;
	localparam logic [ST_W-1:0] ST_UPS   = 5'd15;
	localparam logic [ST_W-1:0] ST_EQ    = 5'd16;
	localparam logic [ST_W-1:0] ST_SPR   = 5'd17;
	localparam logic [ST_W-1:0] ST_SPS   = 5'd18;
	localparam logic [ST_W-1:0] ST_TOPR  = 5'd19;
	localparam logic [ST_W-1:0] ST_TOPG  = 5'd20;
	localparam logic [ST_W-1:0] ST_CRD   = 5'd21;
	localparam logic [ST_W-1:0] ST_CGET  = 5'd22;
	localparam logic [ST_W-1:0] ST_DONE  = 5'd23;

	// controller to datapath
	typedef struct packed {
		logic [ST_W-1:0] op;
		logic            take;
		logic            out_load;
		logic            v_clr;
		logic            v_inc;
		logic            lvl_top;
		logic            lvl_one;
		logic            lvl_inc;
		logic            lvl_dec;
	} lcab_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              v_last;
		logic              v_max;
		logic              lvl_zero;
		logic              lvl_top;
		logic              root;
		logic              dep_ne;
		logic              a_eq_b;
	} lcab_status_t;

endpackage

// ===== design/lcab_channels.sv =====
// lcab_channels: valid/ready channels for input items and result words
// depends on lcab_pkg for field widths
interface lcab_item_if;
	logic                           valid;
	logic                           ready;
	logic [lcab_pkg::FUNC_W-1:0]    func;
	logic [lcab_pkg::NODE_W-1:0]    node_a;
	logic [lcab_pkg::NODE_W-1:0]    node_b;

	modport source (output valid, func, node_a, node_b, input ready);
	modport sink (input valid, func, node_a, node_b, output ready);
endinterface

interface lcab_result_if;
	logic                           valid;
	logic                           ready;
	logic                           is_answer;
	logic [lcab_pkg::NODE_W-1:0]    ancestor;
	logic [lcab_pkg::LEN_W-1:0]     path_length;

	modport source (output valid, is_answer, ancestor, path_length, input ready);
	modport sink (input valid, is_answer, ancestor, path_length, output ready);
endinterface

// ===== design/lcab_ram.sv =====
// lcab_ram: generic memory, one write port and two registered read ports
// no dependencies
module lcab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	output logic [WIDTH-1:0]         ra_data,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

// ===== design/lcab_datapath.sv =====
// lcab_datapath: ancestor and depth memories, node registers, result word
// depends on lcab_pkg and lcab_ram; steered by lcab_ctrl
module lcab_datapath #(
	parameter int MAX_NODES  = lcab_pkg::DEF_MAX_NODES,
	parameter int LOG_LEVELS = lcab_pkg::DEF_LOG_LEVELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lcab_pkg::NODE_W-1:0]   cnt,
	input  logic [lcab_pkg::FUNC_W-1:0]   func,
	input  logic [lcab_pkg::NODE_W-1:0]   node_a,
	input  logic [lcab_pkg::NODE_W-1:0]   node_b,
	input  lcab_pkg::lcab_cmd_t           cmd,
	output lcab_pkg::lcab_status_t        st,
	output logic                          is_answer,
	output logic [lcab_pkg::NODE_W-1:0]   ancestor,
	output logic [lcab_pkg::LEN_W-1:0]    path_length
);

	localparam int AW = $clog2(MAX_NODES + 1);
	localparam int DW = $clog2(MAX_NODES);
	localparam int LW = $clog2(LOG_LEVELS);
	localparam int NW = lcab_pkg::NODE_W;
	localparam int SW = DW + 1;

	logic [lcab_pkg::FUNC_W-1:0] func_q;
	logic [NW-1:0]         a_q, b_q, up_q, c_q;
	logic [AW-1:0]         v_q;
	logic [LW-1:0]         lvl_q, lvl_m1;
	logic [LOG_LEVELS-1:0] d_q, d_n, d_step;
	logic [DW-1:0]         db_q, dc_q;
	logic [SW-1:0]         sum_q, twice_c, len_w;
	logic                  ans_q;
	logic [NW-1:0]         anc_out_q;
	logic [lcab_pkg::LEN_W-1:0] len_q;

	// memory ports
	logic [AW-1:0]         anc_ra, anc_rb, anc_wa;
	logic [NW-1:0]         anc_wd;
	logic [LOG_LEVELS-1:0] anc_we;
	logic [NW-1:0]         anc_qa [LOG_LEVELS];
	logic [NW-1:0]         anc_qb [LOG_LEVELS];
	logic [AW-1:0]         dep_ra, dep_rb, dep_wa;
	logic [DW-1:0]         dep_wd, dep_qa, dep_qb;
	logic                  dep_we;

	logic [NW-1:0]         up_n, x_n;
	logic                  load_ok, par_ok;

	// one memory per level, rows indexed by node
	for (genvar g = 0; g < LOG_LEVELS; g++) begin : g_lvl
		lcab_ram #(.WIDTH(NW), .DEPTH(MAX_NODES + 1)) u_anc (
			.clk     (clk),
			.we      (anc_we[g]),
			.waddr   (anc_wa),
			.wdata   (anc_wd),
			.ra_addr (anc_ra),
			.ra_data (anc_qa[g]),
			.rb_addr (anc_rb),
			.rb_data (anc_qb[g])
		);
	end

	lcab_ram #(.WIDTH(DW), .DEPTH(MAX_NODES + 1)) u_dep (
		.clk     (clk),
		.we      (dep_we),
		.waddr   (dep_wa),
		.wdata   (dep_wd),
		.ra_addr (dep_ra),
		.ra_data (dep_qa),
		.rb_addr (dep_rb),
		.rb_data (dep_qb)
	);

	// helpers
	assign lvl_m1  = lvl_q - 1'b1;
	assign up_n    = anc_qa[lvl_q];
	assign d_step  = {{(LOG_LEVELS-1){1'b0}}, 1'b1} << lvl_q;
	assign x_n     = (up_n != lcab_pkg::NULL_NODE) ? up_n : a_q;
	assign d_n     = (up_n != lcab_pkg::NULL_NODE) ? d_q + d_step : d_q;
	assign load_ok = (a_q > lcab_pkg::ROOT_NODE) && (a_q <= cnt);
	assign par_ok  = (b_q != lcab_pkg::NULL_NODE) && (b_q <= cnt);

	// memory addressing and writes per step
	always_comb begin
		anc_ra = AW'(a_q);
		anc_rb = AW'(b_q);
		anc_wa = v_q;
		anc_wd = lcab_pkg::NULL_NODE;
		anc_we = '0;
		dep_ra = AW'(a_q);
		dep_rb = AW'(b_q);
		dep_wa = v_q;
		dep_wd = '0;
		dep_we = 1'b0;
		case (cmd.op)
			lcab_pkg::ST_CLR: begin
				anc_we = '1;
				dep_we = 1'b1;
			end
			lcab_pkg::ST_LOAD: begin
				anc_wa    = AW'(a_q);
				anc_wd    = par_ok ? b_q : lcab_pkg::NULL_NODE;
				anc_we[0] = load_ok;
			end
			lcab_pkg::ST_B0R, lcab_pkg::ST_LVR, lcab_pkg::ST_DPR: begin
				anc_ra = v_q;
			end
			lcab_pkg::ST_B0W: begin
				anc_we[0] = 1'b1;
				if (32'(v_q) <= 32'(lcab_pkg::ROOT_NODE) || anc_qa[0] > cnt) begin
					anc_wd = lcab_pkg::NULL_NODE;
				end else begin
					anc_wd = anc_qa[0];
				end
			end
			lcab_pkg::ST_LVM: begin
				anc_ra = AW'(anc_qa[lvl_m1]);
			end
			lcab_pkg::ST_LVW: begin
				anc_we[lvl_q] = 1'b1;
				anc_wd        = anc_qa[lvl_m1];
			end
			lcab_pkg::ST_DPS: begin
				anc_ra = AW'(x_n);
				dep_we = (lvl_q == '0);
				if (32'(d_n) > 32'(MAX_NODES - 1)) begin
					dep_wd = DW'(MAX_NODES - 1);
				end else begin
					dep_wd = DW'(d_n);
				end
			end
			lcab_pkg::ST_UPD: begin
				dep_ra = AW'(up_n);
			end
			lcab_pkg::ST_CRD: begin
				dep_ra = AW'(c_q);
			end
			default: begin
			end
		endcase
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			lvl_q <= '0;
		end else begin
			if (cmd.v_clr) begin
				v_q <= '0;
			end else if (cmd.v_inc) begin
				v_q <= v_q + 1'b1;
			end
			if (cmd.lvl_top) begin
				lvl_q <= LW'(LOG_LEVELS - 1);
			end else if (cmd.lvl_one) begin
				lvl_q <= LW'(1);
			end else if (cmd.lvl_inc) begin
				lvl_q <= lvl_q + 1'b1;
			end else if (cmd.lvl_dec) begin
				lvl_q <= lvl_m1;
			end
		end
	end

	// node and depth registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= func;
			a_q    <= node_a;
			b_q    <= node_b;
		end
		case (cmd.op)
			lcab_pkg::ST_DPR: begin
				a_q <= NW'(v_q);
				d_q <= '0;
			end
			lcab_pkg::ST_DPS: begin
				a_q <= x_n;
				d_q <= d_n;
			end
			lcab_pkg::ST_QMAP: begin
				if (a_q > cnt) a_q <= lcab_pkg::NULL_NODE;
				if (b_q > cnt) b_q <= lcab_pkg::NULL_NODE;
			end
			lcab_pkg::ST_QPICK: begin
				c_q   <= lcab_pkg::ROOT_NODE;
				sum_q <= SW'(dep_qa) + SW'(dep_qb);
				if (dep_qa < dep_qb) begin
					a_q  <= b_q;
					b_q  <= a_q;
					db_q <= dep_qa;
				end else begin
					db_q <= dep_qb;
				end
			end
			lcab_pkg::ST_UPD: begin
				up_q <= up_n;
			end
			lcab_pkg::ST_UPS: begin
				if (dep_qa >= db_q) a_q <= up_q;
			end
			lcab_pkg::ST_EQ: begin
				c_q <= a_q;
			end
			lcab_pkg::ST_SPS: begin
				if (anc_qa[lvl_q] != anc_qb[lvl_q]) begin
					a_q <= anc_qa[lvl_q];
					b_q <= anc_qb[lvl_q];
				end
			end
			lcab_pkg::ST_TOPG: begin
				c_q <= anc_qa[0];
			end
			lcab_pkg::ST_CGET: begin
				dc_q <= dep_qa;
			end
			default: begin
			end
		endcase
	end

	// path length through the common ancestor, clamped at zero
	assign twice_c = {dc_q, 1'b0};
	assign len_w   = (sum_q > twice_c) ? sum_q - twice_c : '0;

	// result word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (func_q == lcab_pkg::FN_QUERY) begin
				ans_q     <= 1'b1;
				anc_out_q <= c_q;
				len_q     <= lcab_pkg::LEN_W'(len_w);
			end else begin
				ans_q     <= 1'b0;
				anc_out_q <= lcab_pkg::NULL_NODE;
				len_q     <= '0;
			end
		end
	end

	assign is_answer   = ans_q;
	assign ancestor    = anc_out_q;
	assign path_length = len_q;

	// status; func is that of the word on the input channel
	assign st.func     = func;
	assign st.v_last   = (32'(v_q) == 32'(cnt));
	assign st.v_max    = (v_q == AW'(MAX_NODES));
	assign st.lvl_zero = (lvl_q == '0);
	assign st.lvl_top  = (lvl_q == LW'(LOG_LEVELS - 1));
	assign st.root     = (a_q == lcab_pkg::ROOT_NODE) || (b_q == lcab_pkg::ROOT_NODE);
	assign st.dep_ne   = (dep_qa != dep_qb);
	assign st.a_eq_b   = (a_q == b_q);

endmodule

// ===== design/lcab_ctrl.sv =====
// lcab_ctrl: step sequencer for clearing, load, build and query
// depends on lcab_pkg; drives lcab_datapath through lcab_cmd_t
module lcab_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  lcab_pkg::lcab_status_t st,
	output lcab_pkg::lcab_cmd_t    cmd
);

	logic [lcab_pkg::ST_W-1:0] state_q, state_n;
	logic                      out_valid_q;
	logic                      in_fire;

	assign in_fire = in_valid && in_ready;

	// next step and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		cmd.op   = state_q;
		in_ready = 1'b0;
		case (state_q)
			lcab_pkg::ST_CLR: begin
				if (st.v_max) begin
					cmd.v_clr = 1'b1;
					state_n   = lcab_pkg::ST_IDLE;
				end else begin
					cmd.v_inc = 1'b1;
				end
			end
			lcab_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take  = 1'b1;
					cmd.v_clr = 1'b1;
					// dispatch on the function of the incoming word
					case (st.func)
						lcab_pkg::FN_LOAD:  state_n = lcab_pkg::ST_LOAD;
						lcab_pkg::FN_BUILD: state_n = lcab_pkg::ST_B0R;
						lcab_pkg::FN_QUERY: state_n = lcab_pkg::ST_QMAP;
						default:            state_n = lcab_pkg::ST_DONE;
					endcase
				end
			end
			lcab_pkg::ST_LOAD: state_n = lcab_pkg::ST_DONE;
			lcab_pkg::ST_B0R:  state_n = lcab_pkg::ST_B0W;
			lcab_pkg::ST_B0W: begin
				if (st.v_last) begin
					cmd.v_clr   = 1'b1;
					cmd.lvl_one = 1'b1;
					state_n     = lcab_pkg::ST_LVR;
				end else begin
					cmd.v_inc = 1'b1;
					state_n   = lcab_pkg::ST_B0R;
				end
			end
			lcab_pkg::ST_LVR: state_n = lcab_pkg::ST_LVM;
			lcab_pkg::ST_LVM: state_n = lcab_pkg::ST_LVW;
			lcab_pkg::ST_LVW: begin
				state_n = lcab_pkg::ST_LVR;
				if (st.v_last) begin
					cmd.v_clr = 1'b1;
					if (st.lvl_top) begin
						state_n = lcab_pkg::ST_DPR;
					end else begin
						cmd.lvl_inc = 1'b1;
					end
				end else begin
					cmd.v_inc = 1'b1;
				end
			end
			lcab_pkg::ST_DPR: begin
				cmd.lvl_top = 1'b1;
				state_n     = lcab_pkg::ST_DPS;
			end
			lcab_pkg::ST_DPS: begin
				if (!st.lvl_zero) begin
					cmd.lvl_dec = 1'b1;
				end else if (st.v_last) begin
					cmd.v_clr = 1'b1;
					state_n   = lcab_pkg::ST_DONE;
				end else begin
					cmd.v_inc = 1'b1;
					state_n   = lcab_pkg::ST_DPR;
				end
			end
			lcab_pkg::ST_QMAP: state_n = lcab_pkg::ST_QRD;
			lcab_pkg::ST_QRD:  state_n = lcab_pkg::ST_QPICK;
			lcab_pkg::ST_QPICK: begin
				if (st.root) begin
					state_n = lcab_pkg::ST_CRD;
				end else if (st.dep_ne) begin
					cmd.lvl_top = 1'b1;
					state_n     = lcab_pkg::ST_UPR;
				end else begin
					state_n = lcab_pkg::ST_EQ;
				end
			end
			lcab_pkg::ST_UPR: state_n = lcab_pkg::ST_UPD;
			lcab_pkg::ST_UPD: state_n = lcab_pkg::ST_UPS;
			lcab_pkg::ST_UPS: begin
				if (st.lvl_zero) begin
					state_n = lcab_pkg::ST_EQ;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_n     = lcab_pkg::ST_UPR;
				end
			end
			lcab_pkg::ST_EQ: begin
				if (st.a_eq_b) begin
					state_n = lcab_pkg::ST_CRD;
				end else begin
					cmd.lvl_top = 1'b1;
					state_n     = lcab_pkg::ST_SPR;
				end
			end
			lcab_pkg::ST_SPR: state_n = lcab_pkg::ST_SPS;
			lcab_pkg::ST_SPS: begin
				if (st.lvl_zero) begin
					state_n = lcab_pkg::ST_TOPR;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_n     = lcab_pkg::ST_SPR;
				end
			end
			lcab_pkg::ST_TOPR: state_n = lcab_pkg::ST_TOPG;
			lcab_pkg::ST_TOPG: state_n = lcab_pkg::ST_CRD;
			lcab_pkg::ST_CRD:  state_n = lcab_pkg::ST_CGET;
			lcab_pkg::ST_CGET: state_n = lcab_pkg::ST_DONE;
			lcab_pkg::ST_DONE: begin
				if (!out_valid_q) begin
					cmd.out_load = 1'b1;
					state_n      = lcab_pkg::ST_IDLE;
				end
			end
			default: state_n = lcab_pkg::ST_IDLE;
		endcase
	end

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcab_pkg::ST_CLR;
		end else begin
			state_q <= state_n;
		end
	end

	// result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != lcab_pkg::ST_IDLE)
		else $error("engine idle right after taking a word");
	a_slot_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcab_pkg::ST_DONE && !out_valid_q) |=>
		(out_valid_q && state_q == lcab_pkg::ST_IDLE))
		else $error("finished result not moved to the output slot");
	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcab_pkg::ST_CLR && !st.v_max) |=> state_q == lcab_pkg::ST_CLR)
		else $error("clearing pass left early");
	a_lvl_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lvl_dec |-> !st.lvl_zero)
		else $error("level counter stepped below zero");
`endif

endmodule

// ===== design/lca_binary_lifting_engine_core.sv =====
// lca_binary_lifting_engine_core: top level of the lowest common ancestor engine
// depends on lcab_pkg, lcab_channels, lcab_ctrl and lcab_datapath
//
//  port     dir   role
//  item     sink  func, node_a, node_b: load parent, build tables, query pair
//  result   src   is_answer, ancestor, path_length: one word per item
//  apb      cfg   node_count at byte address 0
//
// after reset a clearing pass over every table row runs before the first item
// query time is set by the dependent table reads on the ancestor and depth memories;
// build walks every node once per level, then once more to fill the depth table
// a waiting result does not block the next item, only its finish
module lca_binary_lifting_engine_core #(
	parameter int MAX_NODES  = lcab_pkg::DEF_MAX_NODES,
	parameter int LOG_LEVELS = lcab_pkg::DEF_LOG_LEVELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lcab_item_if.sink                   item,
	lcab_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lcab_pkg::APB_AW-1:0] paddr,
	input  logic [lcab_pkg::APB_DW-1:0] pwdata,
	output logic [lcab_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	logic [lcab_pkg::CFG_W-1:0]  node_count_q;
	logic [lcab_pkg::NODE_W-1:0] cnt;
	logic                        cfg_wr;
	lcab_pkg::lcab_cmd_t         cmd;
	lcab_pkg::lcab_status_t      st;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == lcab_pkg::REG_NODE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= lcab_pkg::NODE_COUNT_RST;
		end else if (cfg_wr) begin
			node_count_q <= pwdata[lcab_pkg::CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == lcab_pkg::REG_NODE_COUNT) ?
		lcab_pkg::APB_DW'(node_count_q) : '0;

	// nodes in use, clamped to the table size
	assign cnt = (32'(node_count_q) > 32'(MAX_NODES)) ?
		lcab_pkg::NODE_W'(MAX_NODES) : node_count_q;

	lcab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.cmd       (cmd)
	);

	lcab_datapath #(.MAX_NODES(MAX_NODES), .LOG_LEVELS(LOG_LEVELS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cnt         (cnt),
		.func        (item.func),
		.node_a      (item.node_a),
		.node_b      (item.node_b),
		.cmd         (cmd),
		.st          (st),
		.is_answer   (result.is_answer),
		.ancestor    (result.ancestor),
		.path_length (result.path_length)
	);

endmodule
